FILE: design/pcc_pkg.sv
// Shared types and constants for the polar/Cartesian converter.
// Holds the op codes, the pipeline stage record and the CORDIC arctangent table.
// No dependencies.
package pcc_pkg;

  typedef enum logic [1:0] {
    OP_TO_POLAR  = 2'd0,
    OP_TO_CART   = 2'd1,
    OP_MOVE_POLE = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  localparam logic [31:0]        GAIN_K       = 32'h9B74EDA8;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;

  typedef struct packed {
    logic               v;
    op_t                op;
    logic               ov;
    logic               pole;
    logic signed [63:0] gx;
    logic signed [63:0] gy;
    logic signed [33:0] z;
    logic signed [63:0] ax;
    logic signed [63:0] ay;
    logic [63:0]        mh;
    logic [63:0]        ml;
  } stage_t;

  // atan(2^-i) in binary angle units, 2^31 = pi
  function automatic logic [29:0] atan_of(input int i);
    logic [29:0] a;
    unique case (i)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      28: a = 30'd3;
      29: a = 30'd1;
      30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/polar_cartesian_converter.sv
// Polar/Cartesian converter: a rotation CORDIC followed by a vectoring CORDIC, fully pipelined.
// Depends on pcc_pkg.
//
// Usage:
//   Input beat (in_valid/in_ready): op, Cartesian point, polar point, offset.
//     op 0: (cart + shift) to polar. op 1: polar to Cartesian.
//     op 2: polar to Cartesian, add shift, back to polar. op 3: all zero.
//   Result beat (out_valid/out_ready): radius, angle, x, y, overflow.
//   One CORDIC stage per register, so a new beat enters every cycle.
//   Throughput is one beat per cycle while out_ready is high.
//   When the receiver stalls, the whole pipeline holds and in_ready drops;
//   nothing is lost or repeated, and it advances again with out_ready.
//   Reset clears the valid bits of every stage; results in flight are dropped.
module polar_cartesian_converter
  import pcc_pkg::*;
#(
  parameter int DATA_WIDTH    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_cart_x,
  input  logic [31:0] in_cart_y,
  input  logic [31:0] in_radius,
  input  logic [31:0] in_angle,
  input  logic [31:0] in_shift_x,
  input  logic [31:0] in_shift_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_radius,
  output logic [31:0] out_angle,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic        out_overflow
);

  localparam int GUARD = 60 - DATA_WIDTH;
  localparam logic signed [63:0] S_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] S_MIN = -S_MAX - 64'sd1;
  localparam logic [63:0]        U_MAX = (64'd1 << DATA_WIDTH) - 64'd1;
  localparam logic signed [63:0] HALF  = 64'sd1 <<< (GUARD - 1);

  function automatic logic signed [63:0] sat_s(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > S_MAX) r = S_MAX;
    else if (v < S_MIN) r = S_MIN;
    return r;
  endfunction

  function automatic logic hit_s(input logic signed [63:0] v);
    return (v > S_MAX) || (v < S_MIN);
  endfunction

  function automatic logic signed [63:0] sext(input logic [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  logic   en;
  stage_t s1_r, s1_nxt;
  stage_t s2_r, s2_nxt;
  stage_t s4_r, s4_nxt;
  stage_t s5_r, s5_nxt;
  stage_t s7_r, s7_nxt;
  stage_t rot_r [0:CORDIC_STAGES];
  stage_t vec_r [0:CORDIC_STAGES];
  stage_t rot0_nxt, vec0_nxt;

  logic        out_valid_r;
  op_t         out_op_r;
  logic [31:0] out_radius_r, out_angle_r, out_x_r, out_y_r;
  logic        out_overflow_r;
  logic [31:0] out_radius_nxt, out_angle_nxt, out_x_nxt, out_y_nxt;
  logic        out_overflow_nxt;

  // advance everything unless a finished result is waiting
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: input saturation and the op 0 offset sum
  always_comb begin
    logic signed [63:0] cxs, cys, txs, tys, sx, sy;
    logic [63:0]        rads;
    logic               rad_hit;
    op_t                op;
    op   = op_t'(in_op);
    cxs  = sat_s(sext(in_cart_x));
    cys  = sat_s(sext(in_cart_y));
    txs  = sat_s(sext(in_shift_x));
    tys  = sat_s(sext(in_shift_y));
    sx   = sat_s(cxs + txs);
    sy   = sat_s(cys + tys);
    rad_hit = {32'd0, in_radius} > U_MAX;
    rads = rad_hit ? U_MAX : {32'd0, in_radius};
    s1_nxt      = '0;
    s1_nxt.v    = in_valid;
    s1_nxt.op   = op;
    s1_nxt.z    = {{2{in_angle[31]}}, in_angle};
    s1_nxt.ax   = txs;
    s1_nxt.ay   = tys;
    unique case (op)
      OP_TO_POLAR: begin
        s1_nxt.gx = sx;
        s1_nxt.gy = sy;
        s1_nxt.ov = hit_s(sext(in_cart_x)) | hit_s(sext(in_cart_y)) |
                    hit_s(sext(in_shift_x)) | hit_s(sext(in_shift_y)) |
                    hit_s(cxs + txs) | hit_s(cys + tys);
      end
      OP_TO_CART: begin
        s1_nxt.gx = $signed(rads);
        s1_nxt.ov = rad_hit;
      end
      OP_MOVE_POLE: begin
        s1_nxt.gx = $signed(rads);
        s1_nxt.ov = rad_hit | hit_s(sext(in_shift_x)) | hit_s(sext(in_shift_y));
      end
      OP_NONE: begin
        s1_nxt.ov = 1'b0;
      end
    endcase
  end

  // Stage 2: radius times gain, as two 32x32 partial products
  always_comb begin
    logic [63:0] u;
    u         = 64'(s1_r.gx) << GUARD;
    s2_nxt    = s1_r;
    s2_nxt.mh = u[63:32] * GAIN_K;
    s2_nxt.ml = u[31:0] * GAIN_K;
  end

  // Stage 3: sum partial products, fold the angle into the right half plane
  always_comb begin
    logic signed [63:0] rk;
    rk       = $signed(s2_r.mh + (s2_r.ml >> 32));
    rot0_nxt = s2_r;
    if (s2_r.op == OP_TO_CART || s2_r.op == OP_MOVE_POLE) begin
      rot0_nxt.gx = rk;
      rot0_nxt.gy = '0;
      if (s2_r.z > QUARTER_TURN) begin
        rot0_nxt.gx = '0;
        rot0_nxt.gy = rk;
        rot0_nxt.z  = s2_r.z - QUARTER_TURN;
      end else if (s2_r.z < -QUARTER_TURN) begin
        rot0_nxt.gx = '0;
        rot0_nxt.gy = -rk;
        rot0_nxt.z  = s2_r.z + QUARTER_TURN;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    stage_t rot_nxt;
    always_comb begin
      logic signed [63:0] dx, dy;
      logic signed [33:0] at;
      dx = $signed(rot_r[k].gy) >>> k;
      dy = $signed(rot_r[k].gx) >>> k;
      at = $signed({4'd0, atan_of(k)});
      rot_nxt = rot_r[k];
      // op 0 points ride through untouched
      if (rot_r[k].op == OP_TO_CART || rot_r[k].op == OP_MOVE_POLE) begin
        if (rot_r[k].z >= 0) begin
          rot_nxt.gx = rot_r[k].gx - dx;
          rot_nxt.gy = rot_r[k].gy + dy;
          rot_nxt.z  = rot_r[k].z - at;
        end else begin
          rot_nxt.gx = rot_r[k].gx + dx;
          rot_nxt.gy = rot_r[k].gy - dy;
          rot_nxt.z  = rot_r[k].z + at;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) rot_r[k+1].v <= 1'b0;
      else if (en) rot_r[k+1] <= rot_nxt;
    end
  end

  // Stage 4: round the rotation result to Cartesian precision
  always_comb begin
    logic signed [63:0] rx, ry, px, py;
    stage_t             t;
    t  = rot_r[CORDIC_STAGES];
    rx = (t.gx + HALF) >>> GUARD;
    ry = (t.gy + HALF) >>> GUARD;
    px = sat_s(rx);
    py = sat_s(ry);
    s4_nxt = t;
    if (t.op == OP_TO_CART) begin
      s4_nxt.ax = px;
      s4_nxt.ay = py;
      s4_nxt.ov = t.ov | hit_s(rx) | hit_s(ry);
    end else if (t.op == OP_MOVE_POLE) begin
      s4_nxt.gx = px;
      s4_nxt.gy = py;
      s4_nxt.ov = t.ov | hit_s(rx) | hit_s(ry);
    end
  end

  // Stage 5: add the offset for a pole move
  always_comb begin
    logic signed [63:0] sx, sy;
    sx = s4_r.gx + s4_r.ax;
    sy = s4_r.gy + s4_r.ay;
    s5_nxt = s4_r;
    if (s4_r.op == OP_MOVE_POLE) begin
      s5_nxt.gx = sat_s(sx);
      s5_nxt.gy = sat_s(sy);
      s5_nxt.ov = s4_r.ov | hit_s(sx) | hit_s(sy);
    end
  end

  // Stage 6: pole detect and quadrant fold for vectoring
  always_comb begin
    logic signed [63:0] x, y, px, py;
    logic signed [33:0] z0;
    x  = s5_r.gx;
    y  = s5_r.gy;
    px = x;
    py = y;
    z0 = '0;
    if (x < 0) begin
      if (y >= 0) begin
        px = y;
        py = -x;
        z0 = QUARTER_TURN;
      end else begin
        px = -y;
        py = x;
        z0 = -QUARTER_TURN;
      end
    end
    vec0_nxt      = s5_r;
    vec0_nxt.pole = (x == 0) && (y == 0);
    vec0_nxt.gx   = px <<< GUARD;
    vec0_nxt.gy   = py <<< GUARD;
    vec0_nxt.z    = z0;
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    stage_t vec_nxt;
    always_comb begin
      logic signed [63:0] dx, dy;
      logic signed [33:0] at;
      dx = $signed(vec_r[k].gy) >>> k;
      dy = $signed(vec_r[k].gx) >>> k;
      at = $signed({4'd0, atan_of(k)});
      vec_nxt = vec_r[k];
      if (vec_r[k].gy >= 0) begin
        vec_nxt.gx = vec_r[k].gx + dx;
        vec_nxt.gy = vec_r[k].gy - dy;
        vec_nxt.z  = vec_r[k].z + at;
      end else begin
        vec_nxt.gx = vec_r[k].gx - dx;
        vec_nxt.gy = vec_r[k].gy + dy;
        vec_nxt.z  = vec_r[k].z - at;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vec_r[k+1].v <= 1'b0;
      else if (en) vec_r[k+1] <= vec_nxt;
    end
  end

  // Stage 7: clamp magnitude, gain correction partial products
  always_comb begin
    logic [63:0] c;
    stage_t      t;
    t  = vec_r[CORDIC_STAGES];
    c  = (t.gx < 0) ? 64'd0 : 64'(t.gx);
    s7_nxt    = t;
    s7_nxt.mh = c[63:32] * GAIN_K;
    s7_nxt.ml = c[31:0] * GAIN_K;
  end

  // Stage 8: round radius, select result fields by op
  always_comb begin
    logic [63:0] mk, r;
    logic        r_hit;
    mk    = s7_r.mh + (s7_r.ml >> 32);
    r     = (mk + (64'd1 << (GUARD - 1))) >> GUARD;
    r_hit = r > U_MAX;
    out_radius_nxt   = '0;
    out_angle_nxt    = '0;
    out_x_nxt        = '0;
    out_y_nxt        = '0;
    out_overflow_nxt = s7_r.ov;
    unique case (s7_r.op)
      OP_TO_POLAR, OP_MOVE_POLE: begin
        if (!s7_r.pole) begin
          out_radius_nxt   = r_hit ? U_MAX[31:0] : r[31:0];
          out_angle_nxt    = s7_r.z[31:0];
          out_overflow_nxt = s7_r.ov | r_hit;
        end
      end
      OP_TO_CART: begin
        out_x_nxt = s7_r.ax[31:0];
        out_y_nxt = s7_r.ay[31:0];
      end
      OP_NONE: begin
        out_overflow_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.v     <= 1'b0;
      s2_r.v     <= 1'b0;
      rot_r[0].v <= 1'b0;
      s4_r.v     <= 1'b0;
      s5_r.v     <= 1'b0;
      vec_r[0].v <= 1'b0;
      s7_r.v     <= 1'b0;
    end else if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      rot_r[0] <= rot0_nxt;
      s4_r     <= s4_nxt;
      s5_r     <= s5_nxt;
      vec_r[0] <= vec0_nxt;
      s7_r     <= s7_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s7_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_op_r       <= s7_r.op;
      out_radius_r   <= out_radius_nxt;
      out_angle_r    <= out_angle_nxt;
      out_x_r        <= out_x_nxt;
      out_y_r        <= out_y_nxt;
      out_overflow_r <= out_overflow_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_radius   = out_radius_r;
  assign out_angle    = out_angle_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_overflow = out_overflow_r;

  a_cart_no_polar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_op_r == OP_TO_CART |-> out_radius == '0 && out_angle == '0)
    else $error("polar fields set on a to-Cartesian result");

  a_polar_no_cart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_op_r == OP_TO_POLAR || out_op_r == OP_MOVE_POLE)
      |-> out_x == '0 && out_y == '0)
    else $error("Cartesian fields set on a polar result");

  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_op_r == OP_NONE |-> !out_overflow && out_radius == '0)
    else $error("unused op produced a nonzero result");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result valid right after reset");

endmodule
